// File: rtl/ntbdf_pkg.sv
// Shared types and constants for the NTB16 receive deframer.
`timescale 1ns / 1ps
package ntbdf_pkg;

  localparam int SUM_W = 18;  // holds position + 8 + table bytes without wrap

  localparam logic [31:0] NTH_SIG = 32'h484D434E;
  localparam logic [31:0] NDP_SIG = 32'h304D434E;
  localparam int NTH_SIZE    = 12;
  localparam int NDP_SIZE    = 8;
  localparam int NDP_LEN_MIN = 16;
  localparam int ETH_HDR     = 14;
  localparam logic [14:0] MAX_BYTES_RST = 15'd16384;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PULL = 1'b1;
  localparam logic KIND_DGRAM = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_BAD_SIG  = 3'd2,
    ST_TOO_LONG = 3'd3,
    ST_BAD_NDP  = 3'd4,
    ST_NONE     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    A_ZERO, A_SIX, A_EIGHT, A_TEN, A_P, A_P4, A_P6, A_ENTRY
  } addr_sel_t;

  typedef struct packed {
    logic      load;
    logic      load_start;
    logic      load_wr;
    logic      set_addr;
    addr_sel_t addr_sel;
    logic      rd;
    logic      take_seq;
    logic      take_ndp;
    logic      take_wl;
    logic      ent_adv;
    logic      hop_next;
    logic      glitch_clr;
    logic      emit;
    logic      emit_kind;
    status_t   emit_status;
    logic      emit_gzero;
  } dp_cmd_t;

  typedef struct packed {
    logic bc_full;
    logic hdr_short;
    logic nth_sig_ok;
    logic ndp_sig_ok;
    logic blen_big;
    logic p_bad;
    logic wl_small;
    logic tbl_bad;
    logic x_done;
    logic ent_bad;
    logic link_end;
    logic out_free;
  } dp_sts_t;

endpackage

// File: rtl/ntbdf_if.sv
// Channel interfaces: input words, result words, configuration writes.
`timescale 1ns / 1ps
interface ntbdf_item_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, cmd, data_byte, last_byte, input ready);
  modport sink   (input valid, cmd, data_byte, last_byte, output ready);
endinterface

interface ntbdf_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] dgram_offset;
  logic [15:0] dgram_length;
  logic [2:0]  status;
  logic        seq_glitch;
  modport source (output valid, kind, dgram_offset, dgram_length, status, seq_glitch,
                  input ready);
  modport sink   (input valid, kind, dgram_offset, dgram_length, status, seq_glitch,
                  output ready);
endinterface

interface ntbdf_cfg_if;
  logic        valid;
  logic        ready;
  logic [14:0] max_block_bytes;
  modport source (output valid, max_block_bytes, input ready);
  modport sink   (input valid, max_block_bytes, output ready);
endinterface

// File: rtl/ntbdf_dp.sv
// Datapath: block store, byte assembler, parse registers, compares, result register.
`timescale 1ns / 1ps
module ntbdf_dp #(
  parameter int BLOCK_BYTES = 16384,
  parameter int MAX_HOPS    = 50
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          data_byte,
  input  logic                cfg_wr,
  input  logic [14:0]         cfg_data,
  input  ntbdf_pkg::dp_cmd_t  cmd,
  output ntbdf_pkg::dp_sts_t  sts,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                out_kind,
  output logic [15:0]         out_offset,
  output logic [15:0]         out_length,
  output logic [2:0]          out_status,
  output logic                out_glitch
);
  import ntbdf_pkg::*;

  localparam int AW = $clog2(BLOCK_BYTES);
  localparam int CW = $clog2(BLOCK_BYTES + 1);
  localparam int HW = $clog2(MAX_HOPS + 1);
  localparam logic [CW-1:0] BC_FULL  = CW'(BLOCK_BYTES);
  localparam logic [HW-1:0] HOP_INIT = HW'(MAX_HOPS);

  logic [7:0]       mem [BLOCK_BYTES];
  logic [7:0]       rdata;
  logic             rd_vld;
  logic [AW-1:0]    addr;
  logic [CW-1:0]    byte_count;
  logic [31:0]      acc;
  logic [14:0]      max_bytes;
  logic [15:0]      prev_seq;
  logic [15:0]      ndp_pos;
  logic [13:0]      n_ent;
  logic [13:0]      entry_pos;
  logic [HW-1:0]    hop;
  logic             glitch;

  logic [AW-1:0]    wr_addr;
  logic [SUM_W-1:0] addr_wide, bc_w, p_w, p8_w, tbl_end, ent_end;
  logic [15:0]      hi, lo, wl_net;
  logic             seq_g;

  assign hi      = acc[31:16];
  assign lo      = acc[15:0];
  assign bc_w    = SUM_W'(byte_count);
  assign p_w     = SUM_W'(ndp_pos);
  assign p8_w    = p_w + SUM_W'(NDP_SIZE);
  assign tbl_end = p8_w + SUM_W'({n_ent, 2'b00});
  assign ent_end = SUM_W'(lo) + SUM_W'(hi);
  assign wl_net  = hi - 16'(NDP_SIZE);
  assign wr_addr = cmd.load_start ? '0 : byte_count[AW-1:0];

  always_comb begin
    case (cmd.addr_sel)
      A_ZERO:  addr_wide = '0;
      A_SIX:   addr_wide = SUM_W'(6);
      A_EIGHT: addr_wide = SUM_W'(8);
      A_TEN:   addr_wide = SUM_W'(10);
      A_P:     addr_wide = p_w;
      A_P4:    addr_wide = p_w + SUM_W'(4);
      A_P6:    addr_wide = p_w + SUM_W'(6);
      A_ENTRY: addr_wide = p8_w + SUM_W'({entry_pos, 2'b00});
      default: addr_wide = '0;
    endcase
  end

  // sequence continuity; a wrap from 0xffff to 0 and a 0/0 pair both pass
  assign seq_g = (({1'b0, prev_seq} + 17'd1) != {1'b0, hi}) &&
                 ((prev_seq != 16'd0) || (hi != 16'd0)) &&
                 !((prev_seq == 16'hffff) && (hi == 16'd0));

  always_comb begin
    sts.bc_full    = byte_count == BC_FULL;
    sts.hdr_short  = bc_w < SUM_W'(NTH_SIZE + NDP_SIZE);
    sts.nth_sig_ok = acc == NTH_SIG;
    sts.ndp_sig_ok = acc == NDP_SIG;
    sts.blen_big   = hi > {1'b0, max_bytes};
    sts.p_bad      = (ndp_pos == 16'd0) || (p8_w > bc_w);
    sts.wl_small   = hi < 16'(NDP_LEN_MIN);
    sts.tbl_bad    = tbl_end > bc_w;
    sts.x_done     = entry_pos >= n_ent;
    sts.ent_bad    = (lo == 16'd0) || (hi == 16'd0) || (ent_end > bc_w) ||
                     (hi > {1'b0, max_bytes}) || (hi < 16'(ETH_HDR));
    sts.link_end   = (hi == 16'd0) || (hop == '0);
    sts.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load && cmd.load_wr) begin
      mem[wr_addr] <= data_byte;
    end
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
    if (rd_vld) begin
      acc <= {rdata, acc[31:8]};
    end
    if (cmd.set_addr) begin
      addr <= addr_wide[AW-1:0];
    end else if (cmd.rd) begin
      addr <= addr + AW'(1);
    end
    if (cmd.take_wl) begin
      n_ent <= wl_net[15:2];
    end
    if (cmd.emit) begin
      out_kind   <= cmd.emit_kind;
      out_offset <= (cmd.emit_kind == KIND_END) ? 16'd0 : lo;
      out_length <= (cmd.emit_kind == KIND_END) ? 16'd0 : hi;
      out_status <= cmd.emit_status;
      out_glitch <= cmd.emit_gzero ? 1'b0 : glitch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld     <= 1'b0;
      byte_count <= '0;
      max_bytes  <= MAX_BYTES_RST;
      prev_seq   <= '0;
      ndp_pos    <= '0;
      entry_pos  <= '0;
      hop        <= HOP_INIT;
      glitch     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_vld <= cmd.rd;
      if (cfg_wr) begin
        max_bytes <= cfg_data;
      end
      if (cmd.load) begin
        byte_count <= (cmd.load_start ? '0 : byte_count) + CW'(cmd.load_wr);
      end
      if (cmd.glitch_clr) begin
        glitch <= 1'b0;
      end else if (cmd.take_seq) begin
        glitch <= seq_g;
      end
      if (cmd.take_seq) begin
        prev_seq <= hi;
      end
      if (cmd.take_ndp) begin
        ndp_pos   <= hi;
        entry_pos <= '0;
        hop       <= HOP_INIT;
      end else if (cmd.hop_next) begin
        ndp_pos   <= hi;
        entry_pos <= '0;
        hop       <= hop - HW'(1);
      end else if (cmd.ent_adv) begin
        entry_pos <= entry_pos + 14'd1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/ntbdf_ctrl.sv
// Controller: block phase tracking and the header / NDP walk sequencer.
`timescale 1ns / 1ps
module ntbdf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_cmd,
  input  logic               in_last,
  output logic               in_ready,
  input  ntbdf_pkg::dp_sts_t sts,
  output ntbdf_pkg::dp_cmd_t cmd
);
  import ntbdf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_RDW, H_SIG, H_BLEN, H_SEQ, H_NDP,
    N_CHK, N_WL, N_TBL, N_SIG, E_CHK, E_ENT, L_NEXT, S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_LOAD, PH_LOAD_OVF, PH_READY, PH_OVF, PH_WALK
  } phase_t;

  state_t  state, state_next, ret, ret_next;
  phase_t  phase, phase_next;
  logic [1:0] rcnt, rcnt_next;
  logic    e_kind, e_kind_next, e_fin, e_fin_next, e_gzero, e_gzero_next;
  status_t e_status, e_status_next;
  logic    starting, full;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd           = '0;
    cmd.addr_sel  = A_ZERO;
    cmd.emit_status = ST_OK;
    state_next    = state;
    ret_next      = ret;
    phase_next    = phase;
    rcnt_next     = rcnt;
    e_kind_next   = e_kind;
    e_fin_next    = e_fin;
    e_gzero_next  = e_gzero;
    e_status_next = e_status;
    starting      = (phase != PH_LOAD) && (phase != PH_LOAD_OVF);
    full          = !starting && sts.bc_full;

    unique case (state)
      S_IDLE: begin
        if (in_valid && in_cmd == CMD_LOAD) begin
          cmd.load       = 1'b1;
          cmd.load_start = starting;
          cmd.load_wr    = !full;
          cmd.glitch_clr = starting;
          phase_next     = full ? PH_LOAD_OVF : (starting ? PH_LOAD : phase);
          if (in_last) begin
            phase_next = (phase_next == PH_LOAD_OVF) ? PH_OVF : PH_READY;
          end
        end else if (in_valid) begin
          unique case (phase)
            PH_READY: begin
              if (sts.hdr_short) begin
                {e_kind_next, e_status_next, e_fin_next, e_gzero_next} =
                  {KIND_END, ST_SHORT, 1'b1, 1'b0};
                state_next = S_EMIT;
              end else begin
                cmd.set_addr = 1'b1; cmd.addr_sel = A_ZERO;
                rcnt_next = 2'd3; ret_next = H_SIG; state_next = S_RD;
              end
            end
            PH_WALK: state_next = N_CHK;
            PH_OVF: begin
              {e_kind_next, e_status_next, e_fin_next, e_gzero_next} =
                {KIND_END, ST_NONE, 1'b1, 1'b1};
              state_next = S_EMIT;
            end
            default: begin
              {e_kind_next, e_status_next, e_fin_next, e_gzero_next} =
                {KIND_END, ST_NONE, 1'b0, 1'b1};
              state_next = S_EMIT;
            end
          endcase
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        rcnt_next = rcnt - 2'd1;
        if (rcnt == 2'd0) begin
          state_next = S_RDW;
        end
      end
      S_RDW: state_next = ret;
      H_SIG: begin
        if (!sts.nth_sig_ok) begin
          {e_kind_next, e_status_next, e_fin_next, e_gzero_next} =
            {KIND_END, ST_BAD_SIG, 1'b1, 1'b0};
          state_next = S_EMIT;
        end else begin
          cmd.set_addr = 1'b1; cmd.addr_sel = A_EIGHT;
          rcnt_next = 2'd1; ret_next = H_BLEN; state_next = S_RD;
        end
      end
      H_BLEN: begin
        if (sts.blen_big) begin
          {e_kind_next, e_status_next, e_fin_next, e_gzero_next} =
            {KIND_END, ST_TOO_LONG, 1'b1, 1'b0};
          state_next = S_EMIT;
        end else begin
          cmd.set_addr = 1'b1; cmd.addr_sel = A_SIX;
          rcnt_next = 2'd1; ret_next = H_SEQ; state_next = S_RD;
        end
      end
      H_SEQ: begin
        cmd.take_seq = 1'b1;
        cmd.set_addr = 1'b1; cmd.addr_sel = A_TEN;
        rcnt_next = 2'd1; ret_next = H_NDP; state_next = S_RD;
      end
      H_NDP: begin
        cmd.take_ndp = 1'b1;
        state_next   = N_CHK;
      end
      N_CHK: begin
        if (sts.p_bad) begin
          {e_kind_next, e_status_next, e_fin_next, e_gzero_next} =
            {KIND_END, ST_BAD_NDP, 1'b1, 1'b0};
          state_next = S_EMIT;
        end else begin
          cmd.set_addr = 1'b1; cmd.addr_sel = A_P4;
          rcnt_next = 2'd1; ret_next = N_WL; state_next = S_RD;
        end
      end
      N_WL: begin
        if (sts.wl_small) begin
          {e_kind_next, e_status_next, e_fin_next, e_gzero_next} =
            {KIND_END, ST_BAD_NDP, 1'b1, 1'b0};
          state_next = S_EMIT;
        end else begin
          cmd.take_wl = 1'b1;
          state_next  = N_TBL;
        end
      end
      N_TBL: begin
        if (sts.tbl_bad) begin
          {e_kind_next, e_status_next, e_fin_next, e_gzero_next} =
            {KIND_END, ST_BAD_NDP, 1'b1, 1'b0};
          state_next = S_EMIT;
        end else begin
          cmd.set_addr = 1'b1; cmd.addr_sel = A_P;
          rcnt_next = 2'd3; ret_next = N_SIG; state_next = S_RD;
        end
      end
      N_SIG: begin
        if (sts.ndp_sig_ok) begin
          state_next = E_CHK;
        end else begin
          cmd.set_addr = 1'b1; cmd.addr_sel = A_P6;
          rcnt_next = 2'd1; ret_next = L_NEXT; state_next = S_RD;
        end
      end
      E_CHK: begin
        cmd.set_addr = 1'b1;
        state_next   = S_RD;
        if (sts.x_done) begin
          cmd.addr_sel = A_P6; rcnt_next = 2'd1; ret_next = L_NEXT;
        end else begin
          cmd.addr_sel = A_ENTRY; rcnt_next = 2'd3; ret_next = E_ENT;
        end
      end
      E_ENT: begin
        if (sts.ent_bad) begin
          cmd.set_addr = 1'b1; cmd.addr_sel = A_P6;
          rcnt_next = 2'd1; ret_next = L_NEXT; state_next = S_RD;
        end else begin
          cmd.ent_adv = 1'b1;
          phase_next  = PH_WALK;
          {e_kind_next, e_status_next, e_fin_next, e_gzero_next} =
            {KIND_DGRAM, ST_OK, 1'b0, 1'b0};
          state_next = S_EMIT;
        end
      end
      L_NEXT: begin
        if (!sts.link_end) begin
          cmd.hop_next = 1'b1;
          state_next   = N_CHK;
        end else begin
          {e_kind_next, e_status_next, e_fin_next, e_gzero_next} =
            {KIND_END, ST_OK, 1'b1, 1'b0};
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_kind   = e_kind;
          cmd.emit_status = e_status;
          cmd.emit_gzero  = e_gzero;
          if (e_fin) begin
            cmd.glitch_clr = 1'b1;
            phase_next     = PH_IDLE;
          end
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= PH_IDLE;
      ret      <= S_IDLE;
      rcnt     <= '0;
      e_kind   <= KIND_END;
      e_fin    <= 1'b0;
      e_gzero  <= 1'b0;
      e_status <= ST_OK;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      ret      <= ret_next;
      rcnt     <= rcnt_next;
      e_kind   <= e_kind_next;
      e_fin    <= e_fin_next;
      e_gzero  <= e_gzero_next;
      e_status <= e_status_next;
    end
  end

endmodule

// File: rtl/ncm_ntb16_rx_deframer_core.sv
// Top level of the NCM NTB16 receive deframer.
`timescale 1ns / 1ps
// Load a received NTB16 with cmd=0 words, one byte per word and one word per
// cycle, last_byte on the final byte; bytes past BLOCK_BYTES are dropped and the
// block is then answered with status 5. Each cmd=1 word pulls exactly one
// result word: a datagram descriptor (offset, length) or an end-of-block word
// with a status. The store has one read port and every field is read one byte
// per cycle, after a set-up step and followed by a drain step. A pull that ends
// at once goes straight to the result; otherwise the first pull of a block runs
// the header checks (later pulls resume the NDP walk), then each NDP visited is
// checked and read up to a descriptor or the chain end, then the result register
// is loaded; that waits while the previous result is still held. No words are
// taken while a pull is being worked. The result register decouples the output,
// so a pull may be accepted while the previous result still waits.
// The user must write max_block_bytes on the cfg channel only while the block is
// idle; the block does not enforce this. The cfg channel is always ready.
module ncm_ntb16_rx_deframer_core #(
  parameter int BLOCK_BYTES = 16384,
  parameter int MAX_HOPS    = 50
) (
  input logic           clk,
  input logic           rst,
  ntbdf_item_if.sink    item,
  ntbdf_result_if.source result,
  ntbdf_cfg_if.sink     cfg
);
  import ntbdf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // config writes are always accepted
  assign cfg.ready = 1'b1;

  // sequencer: phase of the block, walk of header and NDP chain
  ntbdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_cmd   (item.cmd),
    .in_last  (item.last_byte),
    .in_ready (item.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // block store, field assembly, compares and the result register
  ntbdf_dp #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .MAX_HOPS    (MAX_HOPS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (item.data_byte),
    .cfg_wr     (cfg.valid),
    .cfg_data   (cfg.max_block_bytes),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (result.ready),
    .out_valid  (result.valid),
    .out_kind   (result.kind),
    .out_offset (result.dgram_offset),
    .out_length (result.dgram_length),
    .out_status (result.status),
    .out_glitch (result.seq_glitch)
  );

endmodule

// File: rtl/ntbdf_chk.sv
// Port-level checks for the deframer, bound to the top level.
`timescale 1ns / 1ps
module ntbdf_chk (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [15:0] out_offset,
  input logic [15:0] out_length,
  input logic [2:0]  out_status
);
  import ntbdf_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_dgram_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_DGRAM |-> out_status == ST_OK &&
      out_length >= 16'(ETH_HDR) && out_offset != 16'd0)
    else $error("bad descriptor");

  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_END |-> out_offset == 16'd0 && out_length == 16'd0)
    else $error("end word carries position");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_status <= ST_NONE)
    else $error("status out of range");

endmodule

bind ncm_ntb16_rx_deframer_core ntbdf_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_kind   (result.kind),
  .out_offset (result.dgram_offset),
  .out_length (result.dgram_length),
  .out_status (result.status)
);
